// ===== rtl/dct7_pkg.sv =====
// shared types for the dominant color top-k histogram block
`default_nettype none
package dct7_pkg;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_COLLECT,
		ST_WAIT,
		ST_SCAN,
		ST_FINISH,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic hist_en;
		logic cnt_zero;
		logic cnt_one;
		logic cnt_inc;
		logic clr_wr;
		logic scan_rd;
		logic best_clr;
		logic slot_clr;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic cnt_last;
		logic slot_last;
		logic out_free;
	} status_t;

endpackage
`default_nettype wire

// ===== rtl/dct7_ctrl.sv =====
// controller state machine: clear sweep, pixel collection, ranking scan
`default_nettype none
module dct7_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	input  wire              final_pixel,
	output logic             in_stall,
	input  dct7_pkg::status_t sts,
	output dct7_pkg::cmd_t    cmd
);

	dct7_pkg::state_t state_q, state_d;
	logic accept;

	assign in_stall = (state_q != dct7_pkg::ST_COLLECT);
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dct7_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dct7_pkg::ST_CLEAR: begin
				if (sts.cnt_last) state_d = dct7_pkg::ST_COLLECT;
			end
			dct7_pkg::ST_COLLECT: begin
				if (accept && final_pixel) state_d = dct7_pkg::ST_WAIT;
			end
			dct7_pkg::ST_WAIT: begin
				state_d = dct7_pkg::ST_SCAN;
			end
			dct7_pkg::ST_SCAN: begin
				if (sts.cnt_last) state_d = dct7_pkg::ST_FINISH;
			end
			dct7_pkg::ST_FINISH: begin
				state_d = dct7_pkg::ST_RESULT;
			end
			dct7_pkg::ST_RESULT: begin
				if (sts.out_free) begin
					state_d = sts.slot_last ? dct7_pkg::ST_CLEAR : dct7_pkg::ST_SCAN;
				end
			end
			default: begin
				state_d = dct7_pkg::ST_CLEAR;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			dct7_pkg::ST_CLEAR: begin
				cmd.clr_wr  = 1'b1;
				cmd.cnt_inc = 1'b1;
			end
			dct7_pkg::ST_COLLECT: begin
				cmd.hist_en = accept;
			end
			dct7_pkg::ST_WAIT: begin
				cmd.cnt_one  = 1'b1;
				cmd.best_clr = 1'b1;
				cmd.slot_clr = 1'b1;
			end
			dct7_pkg::ST_SCAN: begin
				cmd.scan_rd = 1'b1;
				cmd.cnt_inc = 1'b1;
			end
			dct7_pkg::ST_FINISH: begin
				cmd = '0;
			end
			dct7_pkg::ST_RESULT: begin
				if (sts.out_free) begin
					cmd.emit     = 1'b1;
					cmd.best_clr = 1'b1;
					cmd.cnt_zero = sts.slot_last;
					cmd.cnt_one  = !sts.slot_last;
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/dct7_dpath.sv =====
// datapath: histogram memory, update with forwarding, max scan, result register
`default_nettype none
module dct7_dpath #(
	parameter int PIXEL_BITS = 8,
	parameter int COUNT_BITS = 21,
	parameter int TOP_COUNT  = 7
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire  [7:0]        pixel_value,
	input  dct7_pkg::cmd_t    cmd,
	output dct7_pkg::status_t sts,
	input  wire               out_stall,
	output logic              out_valid,
	output logic [2:0]        rank,
	output logic [7:0]        color,
	output logic              last_of_run
);

	localparam int NUM_BINS  = 1 << PIXEL_BITS;
	localparam int SLOT_BITS = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;

	logic [COUNT_BITS-1:0] mem [NUM_BINS];

	logic [PIXEL_BITS-1:0] pix;
	logic [PIXEL_BITS-1:0] cnt_q;
	logic [PIXEL_BITS-1:0] rd_addr;
	logic [COUNT_BITS-1:0] rd_q;

	logic                  upd_vld_s1;
	logic [PIXEL_BITS-1:0] upd_addr_s1;
	logic                  fwd_s1;
	logic [COUNT_BITS-1:0] upd_prev_q;
	logic [COUNT_BITS-1:0] upd_old;
	logic [COUNT_BITS-1:0] upd_new;

	logic                  scan_vld_s1;
	logic [PIXEL_BITS-1:0] scan_addr_s1;
	logic [COUNT_BITS-1:0] high_q;
	logic [PIXEL_BITS-1:0] best_q;

	logic [SLOT_BITS-1:0]  slot_q;

	logic                  out_vld_q;
	logic [2:0]            rank_q;
	logic [7:0]            color_q;
	logic                  last_q;

	logic                  wr_en;
	logic [PIXEL_BITS-1:0] wr_addr;
	logic [COUNT_BITS-1:0] wr_data;

	assign pix     = PIXEL_BITS'(pixel_value);
	assign rd_addr = cmd.hist_en ? pix : cnt_q;

	assign upd_old = fwd_s1 ? upd_prev_q : rd_q;
	assign upd_new = (upd_old == '1) ? upd_old : upd_old + COUNT_BITS'(1);

	assign sts.cnt_last  = (cnt_q == '1);
	assign sts.slot_last = (slot_q == SLOT_BITS'(TOP_COUNT - 1));
	assign sts.out_free  = !out_vld_q || !out_stall;

	// one write port: count update, clear sweep, or retire the chosen bin
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cnt_q;
		wr_data = '0;
		if (upd_vld_s1) begin
			wr_en   = 1'b1;
			wr_addr = upd_addr_s1;
			wr_data = upd_new;
		end else if (cmd.clr_wr) begin
			wr_en   = 1'b1;
			wr_addr = cnt_q;
		end else if (cmd.emit && (high_q != '0)) begin
			wr_en   = 1'b1;
			wr_addr = best_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		upd_addr_s1  <= pix;
		scan_addr_s1 <= cnt_q;
		if (upd_vld_s1) begin
			upd_prev_q <= upd_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upd_vld_s1  <= 1'b0;
			fwd_s1      <= 1'b0;
			scan_vld_s1 <= 1'b0;
			cnt_q       <= '0;
			high_q      <= '0;
			best_q      <= '0;
			slot_q      <= '0;
		end else begin
			upd_vld_s1  <= cmd.hist_en;
			fwd_s1      <= cmd.hist_en && upd_vld_s1 && (upd_addr_s1 == pix);
			scan_vld_s1 <= cmd.scan_rd;

			if (cmd.cnt_zero) begin
				cnt_q <= '0;
			end else if (cmd.cnt_one) begin
				cnt_q <= PIXEL_BITS'(1);
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + PIXEL_BITS'(1);
			end

			// strict compare keeps the lowest value on equal counts
			if (cmd.best_clr) begin
				high_q <= '0;
				best_q <= '0;
			end else if (scan_vld_s1 && (rd_q > high_q)) begin
				high_q <= rd_q;
				best_q <= scan_addr_s1;
			end

			if (cmd.slot_clr) begin
				slot_q <= '0;
			end else if (cmd.emit) begin
				slot_q <= slot_q + SLOT_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.emit) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rank_q  <= 3'(slot_q);
			color_q <= best_q[7:0];
			last_q  <= sts.slot_last;
		end
	end

	assign out_valid   = out_vld_q;
	assign rank        = rank_q;
	assign color       = color_q;
	assign last_of_run = last_q;

endmodule
`default_nettype wire

// ===== rtl/dominant_color_top_seven_core.sv =====
// dominant color top level: histogram of palette indices with top-k ranking
// pixels: one transfer per cycle during collection, count written in the cycle after
// per image: after the final pixel, a wait state, then per slot a scan
// (one memory read port sweep plus compare and result), TOP_COUNT results in all
// then a clear sweep of all 2^PIXEL_BITS bins with input stalled
// after reset: the same clear sweep of all bins before the first pixel
`default_nettype none
module dominant_color_top_seven_core #(
	parameter int PIXEL_BITS = 8,
	parameter int COUNT_BITS = 21,
	parameter int TOP_COUNT  = 7
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_stall,
	input  wire  [7:0] pixel_value,
	input  wire        final_pixel,
	output logic       out_valid,
	input  wire        out_stall,
	output logic [2:0] rank,
	output logic [7:0] color,
	output logic       last_of_run
);

	dct7_pkg::cmd_t    cmd;
	dct7_pkg::status_t sts;

	dct7_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.final_pixel (final_pixel),
		.in_stall    (in_stall),
		.sts         (sts),
		.cmd         (cmd)
	);

	dct7_dpath #(
		.PIXEL_BITS (PIXEL_BITS),
		.COUNT_BITS (COUNT_BITS),
		.TOP_COUNT  (TOP_COUNT)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_value (pixel_value),
		.cmd         (cmd),
		.sts         (sts),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.rank        (rank),
		.color       (color),
		.last_of_run (last_of_run)
	);

endmodule
`default_nettype wire

// ===== tb/tb_dominant_color_top_seven_core.sv =====
// testbench for the dominant color top-k histogram block with its own ranking predictor
module tb_dominant_color_top_seven_core;

	localparam int PIXEL_BITS = 8;
	localparam int COUNT_BITS = 21;
	localparam int TOP_COUNT  = 7;
	localparam int NUM_BINS   = 1 << PIXEL_BITS;
	localparam int SETTLE     = 2 * NUM_BINS;

	typedef struct packed {
		logic [2:0] rank;
		logic [7:0] color;
		logic       last;
	} ranked_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] pixel_value;
	logic       final_pixel;
	logic       out_valid;
	logic       out_stall;
	logic [2:0] rank;
	logic [7:0] color;
	logic       last_of_run;

	logic [COUNT_BITS-1:0] hist [NUM_BINS];
	ranked_t               ranking_q [$];
	ranked_t               want;
	int                    idle_pct;
	int                    stall_pct;
	bit                    failed;

	dominant_color_top_seven_core #(
		.PIXEL_BITS(PIXEL_BITS),
		.COUNT_BITS(COUNT_BITS),
		.TOP_COUNT (TOP_COUNT)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.pixel_value(pixel_value),
		.final_pixel(final_pixel),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.rank       (rank),
		.color      (color),
		.last_of_run(last_of_run)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// counts one pixel and, on the final one, ranks the colors and clears the histogram
	task automatic tally_pixel(input logic [7:0] value, input logic fin);
		int            best;
		logic [COUNT_BITS-1:0] high;
		ranked_t       r;
		if (hist[value] != {COUNT_BITS{1'b1}})
			hist[value] = hist[value] + 1'b1;
		if (fin) begin
			for (int slot = 0; slot < TOP_COUNT; slot++) begin
				best = 0;
				high = '0;
				for (int v = 1; v < NUM_BINS; v++) begin
					if (hist[v] > high) begin
						high = hist[v];
						best = v;
					end
				end
				if (high != 0)
					hist[best] = '0;
				r.rank  = slot[2:0];
				r.color = best[7:0];
				r.last  = (slot == TOP_COUNT - 1);
				ranking_q.push_back(r);
			end
			for (int v = 0; v < NUM_BINS; v++)
				hist[v] = '0;
		end
	endtask

	task automatic send_pixel(input logic [7:0] value, input logic fin);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		pixel_value <= value;
		final_pixel <= fin;
		do @(posedge clk); while (in_stall);
		tally_pixel(value, fin);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (ranking_q.size() != 0);
	endtask

	task automatic send_list(input logic [7:0] values [$]);
		foreach (values[k])
			send_pixel(values[k], k == values.size() - 1);
	endtask

	// zero never ranked, top value wins, missing slots give zero
	task automatic test_extremes();
		send_list('{8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd1});
		wait_drained();
	endtask

	task automatic test_single_pixel();
		send_pixel(8'd0, 1'b1);
		send_pixel(8'd128, 1'b1);
		wait_drained();
	endtask

	// lower value wins among equal counts
	task automatic test_ties();
		send_list('{8'd9, 8'd3, 8'd200, 8'd9, 8'd3, 8'd200, 8'd77});
		wait_drained();
	endtask

	// more distinct values than slots
	task automatic test_full_ranking();
		send_list('{8'd240, 8'd17, 8'd100, 8'd64, 8'd2, 8'd128, 8'd33, 8'd8,
			8'd250, 8'd250, 8'd250});
		wait_drained();
	endtask

	// long runs of one value, then a tie between two runs of equal length
	task automatic test_repeats();
		for (int k = 0; k < 12; k++)
			send_pixel(8'd6, 1'b0);
		for (int k = 0; k < 12; k++)
			send_pixel(8'd5, 1'b0);
		send_pixel(8'd3, 1'b1);
		wait_drained();
	endtask

	task automatic test_random(input int n_items, input int idle, input int stall);
		logic [7:0] pal [12];
		logic [7:0] value;
		int         npal;
		int         len;
		int         sent;
		idle_pct  = idle;
		stall_pct = stall;
		sent      = 0;
		while (sent < n_items) begin
			len  = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 16);
			npal = $urandom_range(1, 12);
			for (int k = 0; k < npal; k++)
				pal[k] = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 3)
					: $urandom_range(0, 255));
			for (int i = 0; i < len; i++) begin
				value = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
					: pal[$urandom_range(0, npal - 1)];
				send_pixel(value, i == len - 1);
			end
			sent += len;
		end
		wait_drained();
	endtask

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (ranking_q.size() == 0) begin
				$display("%0t: unexpected result rank %0d color %0d last %0d",
					$time, rank, color, last_of_run);
				failed = 1'b1;
			end else begin
				want = ranking_q.pop_front();
				if (rank !== want.rank) begin
					$display("%0t: rank expected %0d actual %0d", $time, want.rank, rank);
					failed = 1'b1;
				end
				if (color !== want.color) begin
					$display("%0t: color expected %0d actual %0d", $time, want.color, color);
					failed = 1'b1;
				end
				if (last_of_run !== want.last) begin
					$display("%0t: last_of_run expected %0d actual %0d",
						$time, want.last, last_of_run);
					failed = 1'b1;
				end
			end
		end
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	initial begin
		#50_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		pixel_value = '0;
		final_pixel = 1'b0;
		out_stall   = 1'b0;
		idle_pct    = 0;
		stall_pct   = 0;
		failed      = 1'b0;
		for (int v = 0; v < NUM_BINS; v++)
			hist[v] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extremes();
		test_single_pixel();
		test_ties();
		test_full_ranking();
		idle_pct = 18;
		test_repeats();
		test_random(54, 0, 0);
		test_random(54, 82, 0);
		test_random(54, 0, 82);
		test_random(54, 18, 18);

		repeat (SETTLE) @(posedge clk);
		if (!failed && ranking_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ===== dominant_color_top_seven_core.f =====
rtl/dct7_pkg.sv
rtl/dct7_ctrl.sv
rtl/dct7_dpath.sv
rtl/dominant_color_top_seven_core.sv
tb/tb_dominant_color_top_seven_core.sv
